### design/owts_pkg.sv
// owts_pkg: shared types and constants for the 1-wire temperature read block
// register indexes, reset timings, sequencer phases and the result word layout
// no dependencies
package owts_pkg;

	localparam int CFG_W              = 16;
	localparam int CFG_IDX_W          = 3;
	localparam int COUNTER_BITS_DEF   = 16;
	localparam int TEMP_W             = 16;
	localparam int IN_DATA_W          = 8;
	localparam int OUT_DATA_W         = 24;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_SLOT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_READ_RECOVER  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BYTE_GAP      = 3'd6;

	localparam logic [CFG_W-1:0] RST_RESET_LOW     = 16'd478;
	localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT = 16'd54;
	localparam logic [CFG_W-1:0] RST_RESET_TAIL    = 16'd423;
	localparam logic [CFG_W-1:0] RST_WRITE_SLOT    = 16'd58;
	localparam logic [CFG_W-1:0] RST_READ_SAMPLE   = 16'd10;
	localparam logic [CFG_W-1:0] RST_READ_RECOVER  = 16'd45;
	localparam logic [CFG_W-1:0] RST_BYTE_GAP      = 16'd98;

	// bus commands
	localparam logic [7:0] CMD_SKIP_ROM   = 8'hcc;
	localparam logic [7:0] CMD_CONVERT    = 8'h44;
	localparam logic [7:0] CMD_READ_SCRAT = 8'hbe;

	// command steps of the whole read
	localparam logic [3:0] STEP_RESET_A   = 4'd0;
	localparam logic [3:0] STEP_SKIP_A    = 4'd1;
	localparam logic [3:0] STEP_CONVERT   = 4'd2;
	localparam logic [3:0] STEP_POLL      = 4'd3;
	localparam logic [3:0] STEP_RESET_B   = 4'd4;
	localparam logic [3:0] STEP_SKIP_B    = 4'd5;
	localparam logic [3:0] STEP_READ_CMD  = 4'd6;
	localparam logic [3:0] STEP_READ_LO   = 4'd7;
	localparam logic [3:0] STEP_READ_HI   = 4'd8;

	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_START = 1'b1;

	typedef enum logic [11:0] {
		PH_IDLE     = 12'b0000_0000_0001,
		PH_RST_PRE  = 12'b0000_0000_0010,
		PH_RST_LOW  = 12'b0000_0000_0100,
		PH_RST_WAIT = 12'b0000_0000_1000,
		PH_RST_TAIL = 12'b0000_0001_0000,
		PH_WR_LOW   = 12'b0000_0010_0000,
		PH_WR_HOLD  = 12'b0000_0100_0000,
		PH_WR_REC   = 12'b0000_1000_0000,
		PH_WR_GAP   = 12'b0001_0000_0000,
		PH_RD_LOW   = 12'b0010_0000_0000,
		PH_RD_WAIT  = 12'b0100_0000_0000,
		PH_RD_REC   = 12'b1000_0000_0000
	} phase_t;

	typedef struct packed {
		logic [CFG_W-1:0] reset_low;
		logic [CFG_W-1:0] presence_wait;
		logic [CFG_W-1:0] reset_tail;
		logic [CFG_W-1:0] write_slot;
		logic [CFG_W-1:0] read_sample;
		logic [CFG_W-1:0] read_recover;
		logic [CFG_W-1:0] byte_gap;
	} cfg_t;

	typedef struct packed {
		logic              no_device;
		logic [TEMP_W-1:0] temperature;
		logic              done_res;
		logic              busy_res;
		logic              drive_low;
	} res_t;

endpackage

### design/owts_cfg_regs.sv
// owts_cfg_regs: timing register file written over the configuration channel
// uses owts_pkg for register indexes, reset values and cfg_t
module owts_cfg_regs import owts_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low     <= RST_RESET_LOW;
			cfg_q.presence_wait <= RST_PRESENCE_WAIT;
			cfg_q.reset_tail    <= RST_RESET_TAIL;
			cfg_q.write_slot    <= RST_WRITE_SLOT;
			cfg_q.read_sample   <= RST_READ_SAMPLE;
			cfg_q.read_recover  <= RST_READ_RECOVER;
			cfg_q.byte_gap      <= RST_BYTE_GAP;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RESET_LOW:     cfg_q.reset_low     <= wr_data;
				REG_PRESENCE_WAIT: cfg_q.presence_wait <= wr_data;
				REG_RESET_TAIL:    cfg_q.reset_tail    <= wr_data;
				REG_WRITE_SLOT:    cfg_q.write_slot    <= wr_data;
				REG_READ_SAMPLE:   cfg_q.read_sample   <= wr_data;
				REG_READ_RECOVER:  cfg_q.read_recover  <= wr_data;
				REG_BYTE_GAP:      cfg_q.byte_gap      <= wr_data;
				default: ;  // unused index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/owts_seq.sv
// owts_seq: bus sequencer state and its single-pass next-state logic
// uses owts_pkg for phases, command steps, cfg_t and res_t
module owts_seq import owts_pkg::*; #(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic kind,
	input  logic line_in,
	input  cfg_t cfg,
	output res_t res
);

	localparam int CW = (COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W;
	localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};
	localparam logic [COUNTER_BITS-1:0] CNT_ONE = COUNTER_BITS'(1);
	localparam logic [COUNTER_BITS-1:0] CNT_TWO = COUNTER_BITS'(2);

	phase_t                  phase_q, phase_n;
	logic [COUNTER_BITS-1:0] tick_q, tick_n, tick_inc, len;
	logic [2:0]              bit_q, bit_n;
	logic [7:0]              shift_q, shift_n, sb;
	logic [3:0]              cstep_q, cstep_n, step_v;
	logic [TEMP_W-1:0]       word_q, word_n;
	logic                    absent_q, absent_n;
	logic                    done_n, do_step, rbd;

	function automatic logic [COUNTER_BITS-1:0] clip(input logic [CFG_W-1:0] d);
		logic [CW-1:0] ext;
		ext = CW'(d);
		if (ext > CW'(CNT_MAX))
			return CNT_MAX;
		return COUNTER_BITS'(ext);
	endfunction

	always_comb begin
		unique case (phase_q)
			PH_RST_LOW:  len = clip(cfg.reset_low);
			PH_RST_WAIT: len = clip(cfg.presence_wait);
			PH_RST_TAIL: len = clip(cfg.reset_tail);
			PH_WR_HOLD:  len = clip(cfg.write_slot);
			PH_WR_REC:   len = CNT_TWO;
			PH_WR_GAP:   len = clip(cfg.byte_gap);
			PH_RD_WAIT:  len = clip(cfg.read_sample);
			PH_RD_REC:   len = clip(cfg.read_recover);
			default:     len = CNT_ONE;
		endcase
	end

	assign tick_inc = (tick_q < CNT_MAX) ? tick_q + CNT_ONE : tick_q;

	always_comb begin
		phase_n  = phase_q;
		tick_n   = tick_q;
		bit_n    = bit_q;
		shift_n  = shift_q;
		cstep_n  = cstep_q;
		word_n   = word_q;
		absent_n = absent_q;
		done_n   = 1'b0;
		do_step  = 1'b0;
		step_v   = cstep_q;
		rbd      = 1'b0;
		sb       = shift_q;

		if (kind == KIND_START) begin
			if (phase_q == PH_IDLE) begin
				do_step = 1'b1;
				step_v  = STEP_RESET_A;
			end
		end else if (phase_q != PH_IDLE) begin
			tick_n = tick_inc;
			if (tick_inc >= len) begin
				tick_n = '0;
				unique case (phase_q)
					PH_RST_PRE:  phase_n = PH_RST_LOW;
					PH_RST_LOW:  phase_n = PH_RST_WAIT;
					PH_RST_WAIT: begin
						absent_n = line_in;
						phase_n  = PH_RST_TAIL;
					end
					PH_RST_TAIL: begin
						do_step = 1'b1;
						step_v  = cstep_q + 4'd1;
					end
					PH_WR_LOW:   phase_n = PH_WR_HOLD;
					PH_WR_HOLD:  phase_n = PH_WR_REC;
					PH_WR_REC: begin
						if (bit_q == 3'd7) begin
							if (cfg.byte_gap == '0) begin
								do_step = 1'b1;
								step_v  = cstep_q + 4'd1;
							end else begin
								phase_n = PH_WR_GAP;
							end
						end else begin
							bit_n   = bit_q + 3'd1;
							shift_n = {1'b0, shift_q[7:1]};
							phase_n = PH_WR_LOW;
						end
					end
					PH_WR_GAP: begin
						do_step = 1'b1;
						step_v  = cstep_q + 4'd1;
					end
					PH_RD_LOW:   phase_n = PH_RD_WAIT;
					PH_RD_WAIT: begin
						sb = shift_q | (8'(line_in) << bit_q);
						shift_n = sb;
						if (cfg.read_recover == '0)
							rbd = 1'b1;
						else
							phase_n = PH_RD_REC;
					end
					PH_RD_REC:   rbd = 1'b1;
					default:     phase_n = PH_IDLE;
				endcase
			end
		end

		// end of one read bit, and of a read byte on the eighth
		if (rbd) begin
			if (bit_q != 3'd7) begin
				bit_n   = bit_q + 3'd1;
				phase_n = PH_RD_LOW;
			end else if (cstep_q == STEP_POLL) begin
				do_step = 1'b1;
				// a zero byte means conversion still running: read again
				step_v  = (sb != 8'd0) ? cstep_q + 4'd1 : cstep_q;
			end else if (cstep_q == STEP_READ_LO) begin
				word_n  = {8'd0, sb};
				do_step = 1'b1;
				step_v  = cstep_q + 4'd1;
			end else begin
				word_n  = {sb, word_q[7:0]};
				cstep_n = STEP_RESET_A;
				done_n  = 1'b1;
				phase_n = PH_IDLE;
			end
		end

		if (do_step) begin
			cstep_n = step_v;
			tick_n  = '0;
			unique case (step_v)
				STEP_RESET_A, STEP_RESET_B: phase_n = PH_RST_PRE;
				STEP_SKIP_A, STEP_SKIP_B: begin
					shift_n = CMD_SKIP_ROM;
					bit_n   = '0;
					phase_n = PH_WR_LOW;
				end
				STEP_CONVERT: begin
					shift_n = CMD_CONVERT;
					bit_n   = '0;
					phase_n = PH_WR_LOW;
				end
				STEP_READ_CMD: begin
					shift_n = CMD_READ_SCRAT;
					bit_n   = '0;
					phase_n = PH_WR_LOW;
				end
				STEP_POLL, STEP_READ_LO, STEP_READ_HI: begin
					shift_n = '0;
					bit_n   = '0;
					phase_n = PH_RD_LOW;
				end
				default: phase_n = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tick_q   <= '0;
			bit_q    <= '0;
			shift_q  <= '0;
			cstep_q  <= '0;
			word_q   <= '0;
			absent_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_n;
			tick_q   <= tick_n;
			bit_q    <= bit_n;
			shift_q  <= shift_n;
			cstep_q  <= cstep_n;
			word_q   <= word_n;
			absent_q <= absent_n;
		end
	end

	always_comb begin
		unique case (phase_n)
			PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: res.drive_low = 1'b1;
			PH_WR_HOLD:                       res.drive_low = ~shift_n[0];
			default:                          res.drive_low = 1'b0;
		endcase
		res.busy_res    = (phase_n != PH_IDLE);
		res.done_res    = done_n;
		res.temperature = word_n;
		res.no_device   = absent_n;
	end

endmodule

### design/one_wire_temp_sensor_read_top.sv
// one_wire_temp_sensor_read_top: 1-wire bus master running a full temperature read
// uses owts_pkg, owts_cfg_regs and owts_seq
//
// Each input word is either a one-microsecond tick (tuser 0) carrying the sampled bus
// level in tdata bit 0, or a start request (tuser 1). Every accepted word gives exactly
// one result word: the bus drive level for the coming tick (1 = pull low, 0 = release),
// busy, a done pulse, the raw 16-bit scratchpad reading and the no-device flag. One word
// is taken per clock unless the result register is stalled; a word passes through an input
// register and the sequencer's combinational next-state logic into the result register.
// The timing registers may be rewritten only while no word is in flight; a read in
// progress picks up the new values from its next tick.
module one_wire_temp_sensor_read_top import owts_pkg::*; #(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] line_in, rest zero
	input  logic                  s_axis_tuser,   // [0] kind
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] drive_low, [1] busy_res,
	                                              // [2] done_res, [18:3] temperature,
	                                              // [19] no_device, rest zero
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam int RES_W = $bits(res_t);

	cfg_t cfg;
	res_t res;

	logic             valid_s1, kind_s1, line_s1;
	logic             advance;
	logic             m_valid_q;
	logic [RES_W-1:0] m_res_q;

	assign cfg_ready = 1'b1;

	owts_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// word in the input register moves on when the result register is free
	assign advance       = valid_s1 & (~m_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1 <= s_axis_tuser;
			line_s1 <= s_axis_tdata[0];
		end
	end

	owts_seq #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.kind    (kind_s1),
		.line_in (line_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			m_res_q <= res;
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-RES_W){1'b0}}, m_res_q};

	// a finished read is never reported as still busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_res_q[2] |-> !m_res_q[1])
		else $error("done reported while busy");

	// the bus is only pulled low during a sequence
	a_drive_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_res_q[0] |-> m_res_q[1])
		else $error("bus driven low while idle");

	// a word moved into the result register is shown the next cycle
	a_advance_shows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_valid_q)
		else $error("result word lost");

	// input is refused only while a word waits on a stalled result
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && m_valid_q && !m_axis_tready)
		else $error("input stalled without cause");

endmodule
